FILE: rtl/nqm_pkg.sv
`timescale 1ns / 1ps

package nqm_pkg;

	// field widths
	localparam int ADC_W    = 12;
	localparam int WAVE_W   = 13;
	localparam int MAG_W    = 12;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int SEL_W    = 3;

	typedef logic signed [ADC_W-1:0]    adc_t;
	typedef logic signed [WAVE_W-1:0]   wave_t;
	typedef logic        [MAG_W-1:0]    mag_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [CFG_W-1:0]    cfg_data_t;
	typedef logic        [SEL_W-1:0]    sel_t;
	typedef logic                       cfg_index_t;

	// register indexes
	localparam cfg_index_t REG_PHASE_INCREMENT = 1'b0;
	localparam cfg_index_t REG_SOURCE_SELECT   = 1'b1;

	// register reset values
	localparam cfg_data_t PHASE_INCREMENT_RST = 16'd4194;
	localparam sel_t      SOURCE_SELECT_RST   = 3'd0;

	// source select codes
	localparam sel_t SEL_ADC    = 3'd0;
	localparam sel_t SEL_SINE   = 3'd1;
	localparam sel_t SEL_COSINE = 3'd2;
	localparam sel_t SEL_I      = 3'd3;
	localparam sel_t SEL_Q      = 3'd4;
	localparam sel_t SEL_FILT_I = 3'd5;
	localparam sel_t SEL_FILT_Q = 3'd6;
	localparam sel_t SEL_IQ     = 3'd7;

	// pi in Q60 and the table amplitude
	localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
	localparam mag_t        AMPLITUDE = 12'd2048;

	// series denominators (2i)(2i+1), indexed by term number i
	localparam logic [15:1][9:0] SERIES_DEN = {
		10'd930, 10'd812, 10'd702, 10'd600, 10'd506,
		10'd420, 10'd342, 10'd272, 10'd210, 10'd156,
		10'd110, 10'd72,  10'd42,  10'd20,  10'd6
	};

	// (a*b) >> 60, kept to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// trunc(2048*sin(pi/2 * r / 2^qb)), series in Q60, elaboration only
	function automatic mag_t quarter_mag(input int unsigned r, input int unsigned qb);
		logic [63:0] qsize;
		logic [63:0] half_pi;
		logic [63:0] rr;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] res;
		qsize   = 64'd1 << qb;
		half_pi = PI_Q60 >> 1;
		rr      = 64'(r);
		if (rr == 64'd0)
			return '0;
		if (rr >= qsize)
			return AMPLITUDE;
		x    = (half_pi >> qb) * rr + (((half_pi & (qsize - 64'd1)) * rr) >> qb);
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		for (int i = 1; i <= 15; i++) begin
			term = mul_q60(term, x2) / 64'(SERIES_DEN[i]);
			if ((i % 2) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		res = sum >> 49;
		return res[MAG_W-1:0];
	endfunction

endpackage

FILE: rtl/nqm_in_if.sv
`timescale 1ns / 1ps

interface nqm_in_if;
	import nqm_pkg::*;

	logic valid;
	logic ready;
	adc_t adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

FILE: rtl/nqm_out_if.sv
`timescale 1ns / 1ps

interface nqm_out_if;
	import nqm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    last_of_item;

	modport source (output valid, output sample_out, output last_of_item, input ready);
	modport sink (input valid, input sample_out, input last_of_item, output ready);
endinterface

FILE: rtl/nqm_phase.sv
`timescale 1ns / 1ps

module nqm_phase #(
	parameter int PHASE_BITS      = 16,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nqm_pkg::cfg_data_t         phase_increment,
	nqm_in_if.sink                     adc,
	output logic                       addr_valid,
	input  logic                       addr_ready,
	output logic [TABLE_ADDR_BITS-1:0] addr,
	output nqm_pkg::adc_t              addr_adc
);
	import nqm_pkg::*;

	logic [PHASE_BITS-1:0]                 acc_q;
	logic [PHASE_BITS-1:0]                 acc_next;
	logic [PHASE_BITS+CFG_W-1:0]           inc_wide;
	logic [PHASE_BITS+TABLE_ADDR_BITS-1:0] addr_wide;
	logic                                  valid_s1;
	logic [TABLE_ADDR_BITS-1:0]            addr_s1;
	adc_t                                  adc_s1;
	logic                                  take;

	// increment fitted to the accumulator width, then the new phase
	assign inc_wide  = {{PHASE_BITS{1'b0}}, phase_increment};
	assign acc_next  = acc_q + inc_wide[PHASE_BITS-1:0];
	// top address bits of the phase, zero filled when the phase is narrower
	assign addr_wide = {acc_next, {TABLE_ADDR_BITS{1'b0}}};

	assign adc.ready = !valid_s1 || addr_ready;
	assign take      = adc.valid && adc.ready;

	// phase accumulator advances on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			acc_q <= acc_next;
		end
	end

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adc.ready) begin
			valid_s1 <= adc.valid;
		end
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1 <= addr_wide[PHASE_BITS+TABLE_ADDR_BITS-1:PHASE_BITS];
			adc_s1  <= adc.adc_sample;
		end
	end

	assign addr_valid = valid_s1;
	assign addr       = addr_s1;
	assign addr_adc   = adc_s1;

	a_acc_step: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> acc_q == $past(acc_next))
		else $error("phase accumulator did not advance by the increment");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !addr_ready |=> valid_s1 && $stable(addr_s1) && $stable(adc_s1))
		else $error("first stage lost its item while stalled");

endmodule

FILE: rtl/nqm_sine_lut.sv
`timescale 1ns / 1ps

module nqm_sine_lut #(
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       addr_valid,
	output logic                       addr_ready,
	input  logic [TABLE_ADDR_BITS-1:0] addr,
	input  nqm_pkg::adc_t              addr_adc,
	output logic                       wave_valid,
	input  logic                       wave_ready,
	output nqm_pkg::wave_t             sine,
	output nqm_pkg::wave_t             cosine,
	output nqm_pkg::adc_t              wave_adc
);
	import nqm_pkg::*;

	localparam int QB    = TABLE_ADDR_BITS - 2;
	localparam int QSIZE = 1 << QB;

	mag_t          quarter_tab [QSIZE];
	logic [1:0]    quad_s;
	logic [1:0]    quad_c;
	logic [QB-1:0] r;
	logic [QB:0]   arg_s;
	logic [QB:0]   arg_c;
	mag_t          mag_s;
	mag_t          mag_c;
	wave_t         sine_d;
	wave_t         cosine_d;
	logic          valid_s2;
	wave_t         sine_s2;
	wave_t         cosine_s2;
	adc_t          adc_s2;

	// quarter wave table, folded to constants
	for (genvar k = 0; k < QSIZE; k++) begin : g_tab
		assign quarter_tab[k] = quarter_mag(k, QB);
	end

	// quadrant split; cosine sits one quadrant further on
	assign quad_s = addr[TABLE_ADDR_BITS-1:TABLE_ADDR_BITS-2];
	assign quad_c = quad_s + 2'd1;
	assign r      = addr[QB-1:0];

	// mirrored index in odd quadrants, top of the quarter is full scale
	always_comb begin
		arg_s    = quad_s[0] ? ((QB+1)'(QSIZE) - {1'b0, r}) : {1'b0, r};
		arg_c    = quad_c[0] ? ((QB+1)'(QSIZE) - {1'b0, r}) : {1'b0, r};
		mag_s    = arg_s[QB] ? AMPLITUDE : quarter_tab[arg_s[QB-1:0]];
		mag_c    = arg_c[QB] ? AMPLITUDE : quarter_tab[arg_c[QB-1:0]];
		sine_d   = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
		cosine_d = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

	assign addr_ready = !valid_s2 || wave_ready;

	// second stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (addr_ready) begin
			valid_s2 <= addr_valid;
		end
	end

	// second stage payload
	always_ff @(posedge clk) begin
		if (addr_ready && addr_valid) begin
			sine_s2   <= sine_d;
			cosine_s2 <= cosine_d;
			adc_s2    <= addr_adc;
		end
	end

	assign wave_valid = valid_s2;
	assign sine       = sine_s2;
	assign cosine     = cosine_s2;
	assign wave_adc   = adc_s2;

endmodule

FILE: rtl/nqm_mixer.sv
`timescale 1ns / 1ps

module nqm_mixer (
	input  logic            clk,
	input  logic            arst_n,
	input  nqm_pkg::sel_t   source_select,
	input  logic            wave_valid,
	output logic            wave_ready,
	input  nqm_pkg::wave_t  sine,
	input  nqm_pkg::wave_t  cosine,
	input  nqm_pkg::adc_t   wave_adc,
	nqm_out_if.source       mixed
);
	import nqm_pkg::*;

	localparam int PROD_W = WAVE_W + ADC_W;

	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] adj_i;
	logic signed [PROD_W-1:0] adj_q;
	sample_t                  iv;
	sample_t                  qv;
	sample_t                  first_d;
	logic                     two_d;
	logic                     valid_s3;
	sample_t                  first_s3;
	sample_t                  q_s3;
	logic                     two_s3;
	logic                     sent_q;
	logic                     final_now;
	logic                     advance;

	// mixing products, divided by 256 with truncation toward zero
	always_comb begin
		prod_i = sine * wave_adc;
		prod_q = cosine * wave_adc;
		adj_i  = prod_i + (prod_i[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
		adj_q  = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
		iv     = adj_i[SAMPLE_W+7:8];
		qv     = adj_q[SAMPLE_W+7:8];
	end

	// source selection
	always_comb begin
		two_d = 1'b0;
		unique case (source_select) inside
			SEL_ADC:              first_d = {{(SAMPLE_W-ADC_W){wave_adc[ADC_W-1]}}, wave_adc};
			SEL_SINE:             first_d = {{(SAMPLE_W-WAVE_W){sine[WAVE_W-1]}}, sine};
			SEL_COSINE:           first_d = {{(SAMPLE_W-WAVE_W){cosine[WAVE_W-1]}}, cosine};
			SEL_I, SEL_FILT_I:    first_d = iv;
			SEL_Q, SEL_FILT_Q:    first_d = qv;
			SEL_IQ: begin
				first_d = iv;
				two_d   = 1'b1;
			end
			default:              first_d = iv;
		endcase
	end

	// result register frees once its final result is transferred
	assign final_now  = !two_s3 || sent_q;
	assign advance    = !valid_s3 || (mixed.ready && final_now);
	assign wave_ready = advance;

	// result register control; sent_q marks I gone in the I and Q mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			two_s3   <= 1'b0;
			sent_q   <= 1'b0;
		end else if (advance) begin
			valid_s3 <= wave_valid;
			two_s3   <= wave_valid && two_d;
			sent_q   <= 1'b0;
		end else if (mixed.ready) begin
			sent_q   <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && wave_valid) begin
			first_s3 <= first_d;
			q_s3     <= qv;
		end
	end

	assign mixed.valid        = valid_s3;
	assign mixed.sample_out   = sent_q ? q_s3 : first_s3;
	assign mixed.last_of_item = final_now;

	a_sent_iq: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q |-> valid_s3 && two_s3)
		else $error("second result pending outside the I and Q mode");

	a_q_follows: assert property (@(posedge clk) disable iff (!arst_n)
		mixed.valid && mixed.ready && !mixed.last_of_item |=>
			mixed.valid && mixed.last_of_item && sent_q)
		else $error("Q result did not follow the I result");

endmodule

FILE: rtl/nco_quadrature_mixer.sv
`timescale 1ns / 1ps

// NCO and quadrature mixer for a signed 12-bit converter stream.
// Input channel adc carries one sample per transfer; output channel mixed
// carries sample_out and last_of_item, chosen by source_select (sample, sine,
// cosine, I, Q, or I then Q as two transfers with the second marked last).
// Configuration: wr_en with wr_index 0 sets phase_increment, index 1 sets
// source_select; write only while no item is in flight.
// Each item passes the first stage, second stage and result registers before
// its first result is offered. Throughput: one item per cycle while the
// receiver does not stall; in the I and Q mode the single result register
// delivers both values in turn and takes no new item until Q is transferred.
// Pipeline: phase accumulate, sine/cosine quarter-wave lookup, mix and select.
// Reset clears the phase accumulator, empties the pipeline and loads the
// register defaults (increment 4194, raw sample output).
// When the receiver stalls the result register holds and each stage keeps its
// item, so adc.ready drops once all three stages are full.
module nco_quadrature_mixer #(
	parameter int PHASE_BITS      = 16,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  nqm_pkg::cfg_index_t  wr_index,
	input  nqm_pkg::cfg_data_t   wr_data,
	nqm_in_if.sink               adc,
	nqm_out_if.source            mixed
);
	import nqm_pkg::*;

	cfg_data_t                  phase_increment_q;
	sel_t                       source_select_q;
	logic                       addr_valid;
	logic                       addr_ready;
	logic [TABLE_ADDR_BITS-1:0] addr;
	adc_t                       addr_adc;
	logic                       wave_valid;
	logic                       wave_ready;
	wave_t                      sine;
	wave_t                      cosine;
	adc_t                       wave_adc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_increment_q <= PHASE_INCREMENT_RST;
			source_select_q   <= SOURCE_SELECT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PHASE_INCREMENT: phase_increment_q <= wr_data;
				REG_SOURCE_SELECT:   source_select_q   <= wr_data[SEL_W-1:0];
				default: ;
			endcase
		end
	end

	// phase accumulator and first stage
	nqm_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_phase (
		.clk             (clk),
		.arst_n          (arst_n),
		.phase_increment (phase_increment_q),
		.adc             (adc),
		.addr_valid      (addr_valid),
		.addr_ready      (addr_ready),
		.addr            (addr),
		.addr_adc        (addr_adc)
	);

	// sine and cosine lookup
	nqm_sine_lut #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_lut (
		.clk        (clk),
		.arst_n     (arst_n),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr),
		.addr_adc   (addr_adc),
		.wave_valid (wave_valid),
		.wave_ready (wave_ready),
		.sine       (sine),
		.cosine     (cosine),
		.wave_adc   (wave_adc)
	);

	// mixing, selection and result register
	nqm_mixer u_mixer (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_select (source_select_q),
		.wave_valid    (wave_valid),
		.wave_ready    (wave_ready),
		.sine          (sine),
		.cosine        (cosine),
		.wave_adc      (wave_adc),
		.mixed         (mixed)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import nqm_pkg::*;

	localparam int TABLE_SIZE   = 1024;
	localparam int QUARTER      = 256;
	localparam int MIX_SHIFT    = 256;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASES       = 12;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		sample_t value;
		logic    last;
	} mix_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	cfg_index_t wr_index;
	cfg_data_t  wr_data;

	nqm_in_if  adc();
	nqm_out_if mixed();

	nco_quadrature_mixer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.adc      (adc),
		.mixed    (mixed)
	);

	// sine table and oscillator state as the block should hold them
	int          sine_rom [TABLE_SIZE];
	logic [15:0] nco_phase;
	cfg_data_t   nco_step;
	sel_t        out_select;

	adc_t        adc_backlog [$];
	mix_result_t expected_mixed [$];

	int send_gap;
	int recv_stall;
	bit steady;
	int errors;
	int cycles;

	sel_t sel_codes [8] = '{SEL_ADC, SEL_SINE, SEL_COSINE, SEL_I, SEL_Q,
		SEL_FILT_I, SEL_FILT_Q, SEL_IQ};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// quarter-wave magnitude, 2048*sin(pi/2 * r/256) truncated, by Taylor series in Q60
	function automatic int quarter_wave(input int unsigned r);
		logic [63:0]  half_pi;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  acc;
		logic [127:0] prod;
		if (r == 0)
			return 0;
		if (r >= QUARTER)
			return 2048;
		half_pi = PI_Q60 >> 1;
		x       = (half_pi >> 8) * 64'(r) + (((half_pi & 64'hFF) * 64'(r)) >> 8);
		prod    = {64'd0, x} * {64'd0, x};
		x2      = prod[123:60];
		term    = x;
		acc     = x;
		for (int i = 1; i <= 15; i++) begin
			prod = {64'd0, term} * {64'd0, x2};
			term = prod[123:60] / 64'((2 * i) * (2 * i + 1));
			if (i % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return int'(acc >> 49);
	endfunction

	function automatic mix_result_t result_of(input int v, input logic last);
		mix_result_t r;
		r.value = sample_t'(v);
		r.last  = last;
		return r;
	endfunction

	// advance the oscillator, mix, and queue what the selection emits
	task automatic mix_predict(input adc_t sample);
		int idx_s;
		int idx_c;
		int a;
		int s;
		int c;
		int iv;
		int qv;
		nco_phase = nco_phase + nco_step;
		idx_s     = nco_phase[15:6];
		idx_c     = (idx_s + QUARTER) % TABLE_SIZE;
		a         = sample;
		s         = sine_rom[idx_s];
		c         = sine_rom[idx_c];
		iv        = (s * a) / MIX_SHIFT;
		qv        = (c * a) / MIX_SHIFT;
		case (out_select)
			SEL_ADC:               expected_mixed.push_back(result_of(a, 1'b1));
			SEL_SINE:              expected_mixed.push_back(result_of(s, 1'b1));
			SEL_COSINE:            expected_mixed.push_back(result_of(c, 1'b1));
			SEL_I, SEL_FILT_I:     expected_mixed.push_back(result_of(iv, 1'b1));
			SEL_Q, SEL_FILT_Q:     expected_mixed.push_back(result_of(qv, 1'b1));
			default: begin
				expected_mixed.push_back(result_of(iv, 1'b0));
				expected_mixed.push_back(result_of(qv, 1'b1));
			end
		endcase
	endtask

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int pick_gap();
		int k;
		if (steady)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		else if (k < 85)
			return $urandom_range(1, 3);
		else if (k < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic adc_t random_adc();
		case ($urandom_range(0, 9))
			0:       return adc_t'(-2048);
			1:       return adc_t'(2047);
			2:       return adc_t'(int'($urandom_range(0, 8)) - 4);
			default: return adc_t'($urandom);
		endcase
	endfunction

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		if (idx == REG_PHASE_INCREMENT)
			nco_step = val;
		else
			out_select = val[SEL_W-1:0];
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic wait_drain();
		while (adc_backlog.size() != 0 || expected_mixed.size() != 0)
			@(posedge clk);
	endtask

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			adc.valid <= 1'b0;
		end else if (send_gap > 0) begin
			adc.valid <= 1'b0;
			send_gap--;
		end else if (adc_backlog.size() != 0) begin
			adc.valid      <= 1'b1;
			adc.adc_sample <= adc_backlog[0];
		end else begin
			adc.valid <= 1'b0;
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			mixed.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			mixed.ready <= 1'b0;
			recv_stall--;
		end else begin
			mixed.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				recv_stall = pick_gap();
		end
	end

	// monitor: predict on each sample transfer, check each result transfer
	always @(posedge clk) begin
		mix_result_t want;
		if (arst_n && adc.valid && adc.ready) begin
			mix_predict(adc.adc_sample);
			void'(adc_backlog.pop_front());
			send_gap = pick_gap();
		end
		if (arst_n && mixed.valid && mixed.ready) begin
			if (expected_mixed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual sample_out %0d last_of_item %b",
					$time, mixed.sample_out, mixed.last_of_item);
			end else begin
				want = expected_mixed.pop_front();
				if (mixed.sample_out !== want.value || mixed.last_of_item !== want.last) begin
					errors++;
					$display("%0t: expected sample_out %0d last_of_item %b, actual %0d %b",
						$time, want.value, want.last, mixed.sample_out, mixed.last_of_item);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int   m;
		int   quad;
		int   r;
		sel_t sel;
		cfg_data_t step;

		// full-turn sine table from the quarter wave
		for (int k = 0; k < TABLE_SIZE; k++) begin
			quad = k / QUARTER;
			r    = k % QUARTER;
			m    = (quad % 2 == 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
			sine_rom[k] = (quad >= 2) ? -m : m;
		end

		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = REG_PHASE_INCREMENT;
		wr_data        = '0;
		adc.valid      = 1'b0;
		adc.adc_sample = '0;
		mixed.ready    = 1'b0;
		nco_phase      = '0;
		nco_step       = PHASE_INCREMENT_RST;
		out_select     = SOURCE_SELECT_RST;
		steady         = 1'b0;
		send_gap       = 0;
		recv_stall     = 0;
		errors         = 0;
		cycles         = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: raw sample extremes and values around zero
		adc_backlog.push_back(adc_t'(-2048));
		adc_backlog.push_back(adc_t'(2047));
		adc_backlog.push_back(adc_t'(0));
		adc_backlog.push_back(adc_t'(-1));
		wait_drain();

		// quarter-turn phase steps, each selection but the raw sample in turn
		write_reg(REG_PHASE_INCREMENT, cfg_data_t'(16384));
		for (int i = 1; i < 8; i++) begin
			write_reg(REG_SOURCE_SELECT, cfg_data_t'(sel_codes[i]));
			adc_backlog.push_back(adc_t'(-2048));
			adc_backlog.push_back(adc_t'(2047));
			adc_backlog.push_back(adc_t'($urandom));
			wait_drain();
		end

		// random phases, extreme increments first, every selection visited
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       step = '0;
				1:       step = 16'hFFFF;
				2:       step = 16'd1;
				3:       step = 16'h8000;
				default: step = cfg_data_t'($urandom);
			endcase
			write_reg(REG_PHASE_INCREMENT, step);
			sel = (p < 8) ? sel_codes[(p + 3) % 8] : sel_codes[$urandom_range(0, 7)];
			write_reg(REG_SOURCE_SELECT, cfg_data_t'({13'($urandom), sel}));
			steady = (p % 4 == 3);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				adc_backlog.push_back(random_adc());
			wait_drain();
		end

		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/nqm_pkg.sv
rtl/nqm_in_if.sv
rtl/nqm_out_if.sv
rtl/nqm_phase.sv
rtl/nqm_sine_lut.sv
rtl/nqm_mixer.sv
rtl/nco_quadrature_mixer.sv
verif/testbench.sv
